[hw/rtl/eas_pkg.sv]
`timescale 1ns / 1ps
// shared types, widths and helpers for the exhaustive assignment search
// no dependencies
package eas_pkg;

  localparam int MaxJobs = 8;
  localparam int JobW    = 3;   // worker and job index width
  localparam int NW      = 4;   // side length register width
  localparam int CellW   = 16;  // one cost
  localparam int CellAw  = 6;   // cost memory address
  localparam int CountW  = 7;   // load counter, holds up to MaxJobs*MaxJobs
  localparam int SumW    = 19;  // largest sum is MaxJobs * 65535
  localparam int BestW   = 20;  // best total, resets to all ones

  typedef logic [JobW-1:0] job_t;
  typedef job_t [MaxJobs-1:0] order_t;

  typedef struct packed {
    logic init;  // load identity order and first loop positions
    logic step;  // run one level of the permutation advance
  } perm_cmd_t;

  typedef struct packed {
    logic found;      // a new permutation is ready to score
    logic exhausted;  // the last permutation has been scored
  } perm_res_t;

  // 0 acts as 1, values above MaxJobs act as MaxJobs
  function automatic logic [NW-1:0] side_len(input logic [NW-1:0] v);
    logic [NW-1:0] r;
    r = v;
    if (v == '0) r = NW'(1);
    if (v > NW'(MaxJobs)) r = NW'(MaxJobs);
    return r;
  endfunction

  function automatic order_t identity_order();
    order_t r;
    for (int k = 0; k < MaxJobs; k++) r[k] = JobW'(k);
    return r;
  endfunction

  function automatic order_t swap_pos(input order_t o, input job_t p, input job_t q);
    order_t r;
    r    = o;
    r[p] = o[q];
    r[q] = o[p];
    return r;
  endfunction

endpackage

[hw/rtl/eas_cost_ram.sv]
`timescale 1ns / 1ps
// cost matrix storage: one write port, one read port, registered read data
// depends on eas_pkg
module eas_cost_ram (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [eas_pkg::CellAw-1:0] wr_addr_i,
  input  logic [eas_pkg::CellW-1:0]  wr_data_i,
  input  logic                      rd_en_i,
  input  logic [eas_pkg::CellAw-1:0] rd_addr_i,
  output logic [eas_pkg::CellW-1:0]  rd_data_o
);
  import eas_pkg::*;

  logic [CellW-1:0] mem_q [MaxJobs*MaxJobs];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

[hw/rtl/eas_perm_step.sv]
`timescale 1ns / 1ps
// permutation sequencer: swap-and-restore order kept as loop positions per level
// depends on eas_pkg
module eas_perm_step (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [eas_pkg::NW-1:0] n_i,
  input  eas_pkg::perm_cmd_t     cmd_i,
  output eas_pkg::order_t        order_o,
  output eas_pkg::perm_res_t     res_o
);
  import eas_pkg::*;

  order_t order_q, order_d;
  order_t idx_q, idx_d;
  job_t   lv_q, lv_d;

  job_t       deepest;
  job_t       pos;
  logic [NW-1:0] nxt;
  order_t     undone;

  // deepest loop level is n-2, level 0 when n is one
  assign deepest = (n_i >= NW'(2)) ? JobW'(n_i - NW'(2)) : '0;
  assign pos     = idx_q[lv_q];
  assign nxt     = {1'b0, pos} + NW'(1);
  assign undone  = swap_pos(order_q, lv_q, pos);

  always_comb begin
    order_d = order_q;
    idx_d   = idx_q;
    lv_d    = lv_q;
    res_o   = '0;
    if (cmd_i.init) begin
      order_d = identity_order();
      idx_d   = identity_order();
      lv_d    = deepest;
    end else if (cmd_i.step) begin
      if (nxt < n_i) begin
        order_d     = swap_pos(undone, lv_q, nxt[JobW-1:0]);
        idx_d[lv_q] = nxt[JobW-1:0];
        // levels below restart at their own position, which swaps nothing
        for (int k = 0; k < MaxJobs; k++) begin
          if (JobW'(k) > lv_q) idx_d[k] = JobW'(k);
        end
        lv_d        = deepest;
        res_o.found = 1'b1;
      end else begin
        order_d = undone;
        if (lv_q == '0) begin
          res_o.exhausted = 1'b1;
        end else begin
          lv_d = lv_q - JobW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= identity_order();
      idx_q   <= '0;
      lv_q    <= '0;
    end else begin
      order_q <= order_d;
      idx_q   <= idx_d;
      lv_q    <= lv_d;
    end
  end

  assign order_o = order_q;

endmodule

[hw/rtl/exhaustive_assignment_search_top.sv]
`timescale 1ns / 1ps
// exhaustive assignment search: cost load, permutation scoring, answer lines
// depends on eas_pkg, eas_cost_ram, eas_perm_step
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------
//  request   | start, busy               | cost_i
//  result    | result_valid_o (strobe)   | worker_o, job_o, min_total_o, last_o
//  config    | cfg_we_i                  | cfg_wdata_i (side length n)
//
// costs load one per cycle while busy is low; the n*n-th cost raises busy
// each permutation is read one worker at a time through the single read port of
// the cost memory, then tallied, then advanced by the permutation sequencer
// when every permutation has been scored, n result lines follow
// reset clears control state only; the cost memory needs no clearing
// results cannot be held off: one line per cycle once the search ends
module exhaustive_assignment_search_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [eas_pkg::CellW-1:0]  cost_i,
  input  logic                      cfg_we_i,
  input  logic [eas_pkg::NW-1:0]    cfg_wdata_i,
  output logic                      result_valid_o,
  output logic [eas_pkg::JobW-1:0]  worker_o,
  output logic [eas_pkg::JobW-1:0]  job_o,
  output logic [eas_pkg::SumW-1:0]  min_total_o,
  output logic                      last_o
);
  import eas_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCORE = 3'd1;
  localparam logic [2:0] S_TALLY = 3'd2;
  localparam logic [2:0] S_ADV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [NW-1:0]     jobs_q;
  logic [CountW-1:0] load_q;
  job_t              w_q;
  logic [CellAw-1:0] row_q;
  logic [SumW-1:0]   sum_q;
  logic [BestW-1:0]  best_q;
  order_t            best_order_q;

  logic              out_valid_q;
  job_t              out_worker_q;
  job_t              out_job_q;
  logic [SumW-1:0]   out_total_q;
  logic              out_last_q;

  logic [NW-1:0]     n;
  logic [CountW-1:0] cells;
  logic [CountW-1:0] wr_ptr;
  logic              accept;
  logic              last_cost;
  logic              last_worker;

  logic              rd_en;
  logic [CellAw-1:0] rd_addr;
  logic [CellW-1:0]  rd_data;
  logic [SumW-1:0]   total;

  perm_cmd_t         pcmd;
  perm_res_t         pres;
  order_t            order;

  assign n           = side_len(jobs_q);
  assign cells       = CountW'(n) * CountW'(n);
  assign wr_ptr      = (load_q >= cells) ? '0 : load_q;
  assign accept      = start && !busy;
  assign last_cost   = (wr_ptr + CountW'(1)) == cells;
  assign last_worker = ({1'b0, w_q} + NW'(1)) == n;
  assign busy        = (state_q != S_IDLE);

  assign rd_en   = (state_q == S_SCORE);
  assign rd_addr = row_q + {{(CellAw-JobW){1'b0}}, order[w_q]};
  assign total   = sum_q + {{(SumW-CellW){1'b0}}, rd_data};

  assign pcmd.init = accept && last_cost;
  assign pcmd.step = (state_q == S_ADV);

  eas_cost_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_addr_i (wr_ptr[CellAw-1:0]),
    .wr_data_i (cost_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  eas_perm_step u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .n_i     (n),
    .cmd_i   (pcmd),
    .order_o (order),
    .res_o   (pres)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept && last_cost) state_d = S_SCORE;
      S_SCORE: if (last_worker) state_d = S_TALLY;
      S_TALLY: state_d = S_ADV;
      S_ADV: begin
        if (pres.found) state_d = S_SCORE;
        else if (pres.exhausted) state_d = S_EMIT;
      end
      S_EMIT:  if (last_worker) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      jobs_q      <= NW'(4);
      load_q      <= '0;
      w_q         <= '0;
      row_q       <= '0;
      best_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (state_q == S_EMIT);
      if (cfg_we_i) begin
        jobs_q <= cfg_wdata_i;
        load_q <= '0;
      end else if (accept) begin
        load_q <= last_cost ? '0 : wr_ptr + CountW'(1);
      end
      case (state_q)
        S_IDLE: begin
          w_q   <= '0;
          row_q <= '0;
          if (accept && last_cost) best_q <= '1;
        end
        S_SCORE: begin
          if (last_worker) begin
            w_q   <= '0;
            row_q <= '0;
          end else begin
            w_q   <= w_q + JobW'(1);
            row_q <= row_q + CellAw'(n);
          end
        end
        S_TALLY: begin
          // strict compare keeps the first of equal totals
          if ({1'b0, total} < best_q) best_q <= {1'b0, total};
        end
        S_EMIT: begin
          if (last_worker) begin
            w_q    <= '0;
            best_q <= '1;
          end else begin
            w_q <= w_q + JobW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCORE) begin
      // data of worker w-1 arrives while worker w is read
      sum_q <= (w_q == '0) ? '0 : total;
    end
    if (state_q == S_TALLY && ({1'b0, total} < best_q)) begin
      best_order_q <= order;
    end
    if (state_q == S_EMIT) begin
      out_worker_q <= w_q;
      out_job_q    <= best_order_q[w_q];
      out_total_q  <= best_q[SumW-1:0];
      out_last_q   <= last_worker;
    end
  end

  assign result_valid_o = out_valid_q;
  assign worker_o       = out_worker_q;
  assign job_o          = out_job_q;
  assign min_total_o    = out_total_q;
  assign last_o         = out_last_q;

endmodule

[hw/rtl/eas_checker.sv]
`timescale 1ns / 1ps
// port-level checks on the answer lines of the assignment search
// depends on eas_pkg; bound to exhaustive_assignment_search_top
module eas_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      busy,
  input logic                      result_valid_o,
  input logic [eas_pkg::JobW-1:0]  worker_o,
  input logic [eas_pkg::SumW-1:0]  min_total_o,
  input logic                      last_o
);
  import eas_pkg::*;

  // answer lines come back to back until the last one
  a_lines_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("answer lines not contiguous");

  a_worker_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> worker_o == $past(worker_o) + JobW'(1))
    else $error("worker index did not advance by one");

  a_total_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> min_total_o == $past(min_total_o))
    else $error("minimum total changed within one answer");

  // no new request can be taken while an answer is still going out
  a_busy_mid_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("busy low in the middle of an answer");

endmodule

bind exhaustive_assignment_search_top eas_checker u_eas_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .worker_o       (worker_o),
  .min_total_o    (min_total_o),
  .last_o         (last_o)
);

[tb/sv/eas_answer_checker.sv]
`timescale 1ns / 1ps
// answer checker for the exhaustive assignment search: tracks cost loads and
// side length writes, predicts every answer line and compares it on the fly
// depends on eas_pkg
module eas_answer_checker import eas_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [CellW-1:0] cost_i,
  input  logic             cfg_we_i,
  input  logic [NW-1:0]    cfg_wdata_i,
  input  logic             res_valid_i,
  input  logic [JobW-1:0]  worker_i,
  input  logic [JobW-1:0]  job_i,
  input  logic [SumW-1:0]  min_total_i,
  input  logic             last_i,
  output int               errors_o,
  output int               open_lines_o
);

  typedef struct packed {
    job_t            worker;
    job_t            job;
    logic [SumW-1:0] total;
    logic            last;
  } answer_line_t;

  logic [CellW-1:0] cost_grid [MaxJobs*MaxJobs];
  logic [NW-1:0]    side_reg = NW'(4);
  int               loaded_cells = 0;
  order_t           trial_order;
  order_t           best_order;
  logic [BestW-1:0] best_sum;
  answer_line_t     answer_q [$];
  int               err_count = 0;

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int               n;
    int               l;
    int               w;
    int               pos [MaxJobs];
    bit               climb;
    job_t             t;
    logic [BestW-1:0] sum;
    answer_line_t     line;
    if (!rst_ni) begin
      side_reg     = NW'(4);
      loaded_cells = 0;
      answer_q.delete();
      open_lines_o <= 0;
      errors_o     <= err_count;
    end else begin
      if (res_valid_i) begin
        if (answer_q.size() == 0) begin
          err_count++;
          $display("%0t ns: unexpected line, expected none, actual %0d %0d %0d %0d",
                   $time, worker_i, job_i, min_total_i, last_i);
        end else begin
          line = answer_q.pop_front();
          check_field("worker", line.worker, worker_i);
          check_field("job", line.job, job_i);
          check_field("min_total", line.total, min_total_i);
          check_field("last", line.last, last_i);
        end
      end

      // a side length write drops any partial matrix
      if (cfg_we_i) begin
        side_reg     = cfg_wdata_i;
        loaded_cells = 0;
      end

      if (start_i && !busy_i) begin
        n = (side_reg == '0) ? 1 : ((side_reg > MaxJobs) ? MaxJobs : int'(side_reg));
        if (loaded_cells >= n * n) loaded_cells = 0;
        cost_grid[loaded_cells] = cost_i;
        loaded_cells++;
        if (loaded_cells == n * n) begin
          for (w = 0; w < MaxJobs; w++) trial_order[w] = job_t'(w);
          best_sum = '1;
          // swap-and-restore walk, pos[l] is the next slot tried at level l
          l      = 0;
          pos[0] = 0;
          while (l >= 0) begin
            climb = 1'b1;
            if (l + 1 >= n) begin
              sum = '0;
              for (w = 0; w < n; w++) sum = sum + cost_grid[w * n + int'(trial_order[w])];
              // ties keep the earlier permutation
              if (sum < best_sum) begin
                best_sum   = sum;
                best_order = trial_order;
              end
            end else if (pos[l] < n) begin
              t                   = trial_order[l];
              trial_order[l]      = trial_order[pos[l]];
              trial_order[pos[l]] = t;
              l++;
              pos[l] = l;
              climb  = 1'b0;
            end
            if (climb) begin
              l--;
              if (l >= 0) begin
                t                   = trial_order[l];
                trial_order[l]      = trial_order[pos[l]];
                trial_order[pos[l]] = t;
                pos[l]++;
              end
            end
          end
          for (w = 0; w < n; w++) begin
            line.worker = job_t'(w);
            line.job    = best_order[w];
            line.total  = best_sum[SumW-1:0];
            line.last   = (w == n - 1);
            answer_q.push_back(line);
          end
          loaded_cells = 0;
        end
      end

      open_lines_o <= answer_q.size();
      errors_o     <= err_count;
    end
  end

endmodule

[tb/sv/exhaustive_assignment_search_top_tb.sv]
`timescale 1ns / 1ps
// stimulus and verdict for the exhaustive assignment search top level
// depends on eas_pkg, exhaustive_assignment_search_top, eas_answer_checker
module exhaustive_assignment_search_top_tb;
  import eas_pkg::*;

  localparam int CycleLimit = 4_000_000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic [CellW-1:0] cost_i      = '0;
  logic             cfg_we_i    = 1'b0;
  logic [NW-1:0]    cfg_wdata_i = '0;
  logic             busy;
  logic             result_valid_o;
  logic [JobW-1:0]  worker_o;
  logic [JobW-1:0]  job_o;
  logic [SumW-1:0]  min_total_o;
  logic             last_o;

  int errors;
  int open_lines;
  int cycles  = 0;
  int gap_pct = 0;

  // random phases: side length written, matrices sent
  int phase_cfg  [9] = '{1, 2, 3, 4, 5, 6, 7, 15, 3};
  int phase_mats [9] = '{6, 6, 4, 3, 1, 1, 1, 1, 1};
  int idle_pct   [4] = '{0, 57, 0, 7};

  always #5 clk_i = ~clk_i;

  exhaustive_assignment_search_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cost_i         (cost_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .worker_o       (worker_o),
    .job_o          (job_o),
    .min_total_o    (min_total_o),
    .last_o         (last_o)
  );

  eas_answer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cost_i       (cost_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_valid_i  (result_valid_o),
    .worker_i     (worker_o),
    .job_i        (job_o),
    .min_total_i  (min_total_o),
    .last_i       (last_o),
    .errors_o     (errors),
    .open_lines_o (open_lines)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("exhaustive_assignment_search_top_tb: done, errors");
      $finish;
    end
  end

  // mostly wide random, some small values for ties, some extremes
  function automatic logic [CellW-1:0] pick_cost();
    case ($urandom_range(0, 3))
      0:       return CellW'($urandom_range(0, 15));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return CellW'($urandom_range(0, 65535));
    endcase
  endfunction

  // one request, held until the block takes it
  task automatic send_cost(input logic [CellW-1:0] c);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start  <= 1'b1;
    cost_i <= c;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_side(input logic [NW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (open_lines != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int n;
    int k;
    int cut;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset side length, checkerboard of extremes gives many zero-cost ties
    for (k = 0; k < 16; k++) send_cost(((k / 4 + k % 4) % 2 != 0) ? 16'hFFFF : 16'h0000);
    drain();
    // zero acts as side one
    write_side(4'd0);
    send_cost(16'hFFFF);
    drain();
    // restart mid-load, then an all-max matrix where every permutation ties
    write_side(4'd2);
    send_cost(pick_cost());
    send_cost(pick_cost());
    start <= 1'b0;
    write_side(4'd2);
    repeat (4) send_cost(16'hFFFF);
    drain();

    for (k = 0; k < 9; k++) begin
      gap_pct = idle_pct[k % 4];
      write_side(NW'(phase_cfg[k]));
      n = (phase_cfg[k] > MaxJobs) ? MaxJobs : phase_cfg[k];
      // sometimes abandon a partial load with a fresh write
      if (n > 1 && $urandom_range(0, 1) == 1) begin
        cut = $urandom_range(1, (n * n - 1 < 8) ? n * n - 1 : 8);
        repeat (cut) send_cost(pick_cost());
        start <= 1'b0;
        write_side(NW'(phase_cfg[k]));
      end
      repeat (phase_mats[k] * n * n) send_cost(pick_cost());
      drain();
    end

    repeat (16) @(posedge clk_i);
    if (errors == 0 && open_lines == 0) begin
      $display("exhaustive_assignment_search_top_tb: done, clean");
    end else begin
      $display("exhaustive_assignment_search_top_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/eas_pkg.sv
hw/rtl/eas_cost_ram.sv
hw/rtl/eas_perm_step.sv
hw/rtl/exhaustive_assignment_search_top.sv
hw/rtl/eas_checker.sv
tb/sv/eas_answer_checker.sv
tb/sv/exhaustive_assignment_search_top_tb.sv
